// File: rtl/core/gamepad_deadzone_and_button_edges_defines.svh
// Assertion macros for the gamepad dead-zone block.
// No dependencies; included by the top level only.
`ifndef GAMEPAD_DEADZONE_AND_BUTTON_EDGES_DEFINES_SVH
`define GAMEPAD_DEADZONE_AND_BUTTON_EDGES_DEFINES_SVH

// Check a consequence in the same cycle as its cause
`define GPDZ_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gpdz: same-cycle check failed");

// Check a consequence in the cycle after its cause
`define GPDZ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gpdz: next-cycle check failed");

`endif

// File: rtl/core/gpdz_pkg.sv
// Shared types and constants for the gamepad dead-zone block.
// No dependencies; used by gpdz_iter and the top level.
package gpdz_pkg;

    // Fixed-point value that stands for 1.0
    localparam logic [14:0] UNIT_SCALE = 15'd32767;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_LEFT_DZ  = 2'd0;
    localparam logic [1:0] CFG_RIGHT_DZ = 2'd1;
    localparam logic [1:0] CFG_TRIG_THR = 2'd2;

    // Operations of the shared iterative unit
    typedef enum logic {
        OP_SQRT,
        OP_DIV
    } gpdz_op_t;

    typedef struct packed {
        logic     start;
        gpdz_op_t op;
    } gpdz_iter_ctrl_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_T,
        ST_CHECK,
        ST_ROOT_WAIT,
        ST_LIMIT,
        ST_NX,
        ST_DIVX_GO,
        ST_DIVX_WAIT,
        ST_DIVY_GO,
        ST_DIVY_WAIT,
        ST_STICK_END,
        ST_TRIG_CHK,
        ST_TRIG_GO,
        ST_TRIG_WAIT,
        ST_TRIG_END,
        ST_DONE
    } gpdz_state_t;

endpackage

// File: rtl/core/gamepad_deadzone_and_button_edges.sv
// Gamepad radial stick dead zones, linear trigger dead zones, button edges.
// Uses gpdz_pkg, gpdz_iter and the assertion macro header.
// Each poll runs gpdz_iter 8 times at most: a root and two divides per stick and one divide
// per trigger, fewer when a stick or trigger lies in its dead zone. The output register
// holds a result while the next poll runs; a new poll is taken only once the sequencer
// is back in idle. Reset (aresetn low, synchronous) clears handshakes, sequencer and button
// history, and loads the register defaults 7849, 8689 and 30.
`include "gamepad_deadzone_and_button_edges_defines.svh"
module gamepad_deadzone_and_button_edges #(
    parameter int STICK_FULL_SCALE   = 32767,
    parameter int TRIGGER_FULL_SCALE = 255
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_left_stick_x,
    input  logic signed [15:0] s_left_stick_y,
    input  logic [7:0]         s_left_trigger,
    input  logic signed [15:0] s_right_stick_x,
    input  logic signed [15:0] s_right_stick_y,
    input  logic [7:0]         s_right_trigger,
    input  logic [15:0]        s_buttons,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_left_x_out,
    output logic signed [15:0] m_left_y_out,
    output logic [14:0]        m_left_trigger_out,
    output logic signed [15:0] m_right_x_out,
    output logic signed [15:0] m_right_y_out,
    output logic [14:0]        m_right_trigger_out,
    output logic [13:0]        m_held_mask,
    output logic [13:0]        m_pressed_mask,
    output logic [13:0]        m_released_mask
);
    import gpdz_pkg::*;

    localparam logic [14:0] STICK_FS = 15'(STICK_FULL_SCALE);
    localparam logic [7:0]  TRIG_FS  = 8'(TRIGGER_FULL_SCALE);

    // Configuration registers
    logic [14:0] lsdz_reg;
    logic [14:0] rsdz_reg;
    logic [7:0]  thr_reg;

    // Sequencer
    gpdz_state_t state_reg;
    gpdz_state_t state_next;
    logic        lane_reg;

    // Latched poll
    logic [15:0] lx_reg;
    logic [15:0] ly_reg;
    logic [15:0] rx_reg;
    logic [15:0] ry_reg;
    logic [7:0]  lt_reg;
    logic [7:0]  rt_reg;
    logic [13:0] prev_held_reg;
    logic [13:0] held_reg;
    logic [13:0] pressed_reg;
    logic [13:0] released_reg;

    // Working values
    logic [31:0] s_reg;
    logic [44:0] prod_reg;
    logic [30:0] ux_reg;
    logic [30:0] uy_reg;
    logic [15:0] m_reg;
    logic [14:0] ct_reg;
    logic [30:0] den_reg;
    logic [14:0] qx_reg;

    // Finished results of the running poll
    logic [15:0] res_lx_reg;
    logic [15:0] res_ly_reg;
    logic [15:0] res_rx_reg;
    logic [15:0] res_ry_reg;
    logic [14:0] res_lt_reg;
    logic [14:0] res_rt_reg;

    // Output register
    logic        m_valid_reg;
    logic [15:0] out_lx_reg;
    logic [15:0] out_ly_reg;
    logic [15:0] out_rx_reg;
    logic [15:0] out_ry_reg;
    logic [14:0] out_lt_reg;
    logic [14:0] out_rt_reg;
    logic [13:0] out_held_reg;
    logic [13:0] out_pressed_reg;
    logic [13:0] out_released_reg;

    // Lane-selected operands and conditions
    logic [15:0] cur_x;
    logic [15:0] cur_y;
    logic [14:0] cur_t;
    logic [7:0]  cur_z;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [30:0] ux;
    logic [30:0] uy;
    logic [14:0] clamp_m;
    logic [7:0]  clamp_z;
    logic        stick_dead;
    logic        limit_dead;
    logic        trig_dead;
    logic [13:0] held_in;
    logic        accept;
    logic        out_load;

    // Conditions watched by the checks
    logic        edges_overlap;
    logic        pressed_unheld;
    logic        iter_in_wait;

    // Shared multiplier
    logic        mul_en;
    logic [30:0] mul_a;
    logic [15:0] mul_b;
    logic [46:0] mul_full;

    // Shared root/divide unit
    gpdz_iter_ctrl_t iter_ctrl;
    logic [44:0]     iter_num;
    logic [30:0]     iter_den;
    logic [15:0]     iter_result;
    logic            iter_done;

    gpdz_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (iter_ctrl),
        .num     (iter_num),
        .den     (iter_den),
        .result  (iter_result),
        .done    (iter_done)
    );

    // Pick the stick or trigger of the current lane
    assign cur_x = lane_reg ? rx_reg : lx_reg;
    assign cur_y = lane_reg ? ry_reg : ly_reg;
    assign cur_t = lane_reg ? rsdz_reg : lsdz_reg;
    assign cur_z = lane_reg ? rt_reg : lt_reg;
    assign ax    = cur_x[15] ? (~cur_x + 16'd1) : cur_x;
    assign ay    = cur_y[15] ? (~cur_y + 16'd1) : cur_y;
    assign ux    = {ax, 15'd0} - {15'd0, ax};
    assign uy    = {ay, 15'd0} - {15'd0, ay};

    assign stick_dead = (cur_t >= STICK_FS) || (s_reg <= {2'd0, prod_reg[29:0]});
    assign clamp_m    = (m_reg < {1'b0, STICK_FS}) ? m_reg[14:0] : STICK_FS;
    assign limit_dead = (clamp_m <= cur_t);
    assign trig_dead  = (thr_reg >= TRIG_FS) || (cur_z <= thr_reg);
    assign clamp_z    = (cur_z < TRIG_FS) ? cur_z : TRIG_FS;

    assign held_in  = {s_buttons[15:12], s_buttons[9:0]};
    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_valid) state_next = ST_SQ_X;
            ST_SQ_X:      state_next = ST_SQ_Y;
            ST_SQ_Y:      state_next = ST_SQ_T;
            ST_SQ_T:      state_next = ST_CHECK;
            ST_CHECK:     state_next = stick_dead ? ST_STICK_END : ST_ROOT_WAIT;
            ST_ROOT_WAIT: if (iter_done) state_next = ST_LIMIT;
            ST_LIMIT:     state_next = limit_dead ? ST_STICK_END : ST_NX;
            ST_NX:        state_next = ST_DIVX_GO;
            ST_DIVX_GO:   state_next = ST_DIVX_WAIT;
            ST_DIVX_WAIT: if (iter_done) state_next = ST_DIVY_GO;
            ST_DIVY_GO:   state_next = ST_DIVY_WAIT;
            ST_DIVY_WAIT: if (iter_done) state_next = ST_STICK_END;
            ST_STICK_END: state_next = lane_reg ? ST_TRIG_CHK : ST_SQ_X;
            ST_TRIG_CHK:  state_next = trig_dead ? ST_TRIG_END : ST_TRIG_GO;
            ST_TRIG_GO:   state_next = ST_TRIG_WAIT;
            ST_TRIG_WAIT: if (iter_done) state_next = ST_TRIG_END;
            ST_TRIG_END:  state_next = lane_reg ? ST_DONE : ST_TRIG_CHK;
            ST_DONE:      if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, multiplier and unit controls
    always_comb begin
        s_ready         = 1'b0;
        mul_en          = 1'b0;
        mul_a           = 31'd0;
        mul_b           = 16'd0;
        iter_ctrl.start = 1'b0;
        iter_ctrl.op    = OP_DIV;
        iter_num        = prod_reg;
        iter_den        = den_reg;
        case (state_reg)
            ST_IDLE: s_ready = aresetn;
            ST_SQ_X: begin
                mul_en = 1'b1;
                mul_a  = {15'd0, ax};
                mul_b  = ax;
            end
            ST_SQ_Y: begin
                mul_en = 1'b1;
                mul_a  = {15'd0, ay};
                mul_b  = ay;
            end
            ST_SQ_T: begin
                mul_en = 1'b1;
                mul_a  = {16'd0, cur_t};
                mul_b  = {1'b0, cur_t};
            end
            ST_CHECK: begin
                iter_ctrl.start = !stick_dead;
                iter_ctrl.op    = OP_SQRT;
                iter_num        = {13'd0, s_reg};
            end
            ST_LIMIT: begin
                mul_en = !limit_dead;
                mul_a  = {15'd0, m_reg};
                mul_b  = {1'b0, STICK_FS - cur_t};
            end
            ST_NX: begin
                mul_en = 1'b1;
                mul_a  = ux_reg;
                mul_b  = {1'b0, ct_reg};
            end
            ST_DIVX_GO: begin
                iter_ctrl.start = 1'b1;
                mul_en          = 1'b1;
                mul_a           = uy_reg;
                mul_b           = {1'b0, ct_reg};
            end
            ST_DIVY_GO: iter_ctrl.start = 1'b1;
            ST_TRIG_CHK: begin
                mul_en = !trig_dead;
                mul_a  = {16'd0, UNIT_SCALE};
                mul_b  = {8'd0, clamp_z - thr_reg};
            end
            ST_TRIG_GO: begin
                iter_ctrl.start = 1'b1;
                iter_den        = {23'd0, TRIG_FS - thr_reg};
            end
            default: ;
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // Control state: sequencer, lane, configuration, output handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            lane_reg      <= 1'b0;
            lsdz_reg      <= 15'd7849;
            rsdz_reg      <= 15'd8689;
            thr_reg       <= 8'd30;
            prev_held_reg <= 14'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                lane_reg      <= 1'b0;
                prev_held_reg <= held_in;
            end else if (state_reg inside {ST_STICK_END, ST_TRIG_END}) begin
                lane_reg <= ~lane_reg;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_LEFT_DZ:  lsdz_reg <= cfg_data;
                    CFG_RIGHT_DZ: rsdz_reg <= cfg_data;
                    CFG_TRIG_THR: thr_reg  <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // Datapath: latch the poll, step through stick and trigger work
    always_ff @(posedge aclk) begin
        if (accept) begin
            lx_reg       <= s_left_stick_x;
            ly_reg       <= s_left_stick_y;
            rx_reg       <= s_right_stick_x;
            ry_reg       <= s_right_stick_y;
            lt_reg       <= s_left_trigger;
            rt_reg       <= s_right_trigger;
            held_reg     <= held_in;
            pressed_reg  <= held_in & ~prev_held_reg;
            released_reg <= prev_held_reg & ~held_in;
        end
        if (mul_en) prod_reg <= mul_full[44:0];
        case (state_reg)
            ST_SQ_X: ux_reg <= ux;
            ST_SQ_Y: begin
                uy_reg <= uy;
                s_reg  <= {1'b0, prod_reg[30:0]};
            end
            ST_SQ_T: s_reg <= s_reg + {1'b0, prod_reg[30:0]};
            ST_CHECK: begin
                if (stick_dead) begin
                    if (lane_reg) begin
                        res_rx_reg <= 16'd0;
                        res_ry_reg <= 16'd0;
                    end else begin
                        res_lx_reg <= 16'd0;
                        res_ly_reg <= 16'd0;
                    end
                end
            end
            ST_ROOT_WAIT: if (iter_done) m_reg <= iter_result;
            ST_LIMIT: begin
                ct_reg <= clamp_m - cur_t;
                if (limit_dead) begin
                    if (lane_reg) begin
                        res_rx_reg <= 16'd0;
                        res_ry_reg <= 16'd0;
                    end else begin
                        res_lx_reg <= 16'd0;
                        res_ly_reg <= 16'd0;
                    end
                end
            end
            ST_NX: den_reg <= prod_reg[30:0];
            ST_DIVX_WAIT: if (iter_done) qx_reg <= iter_result[14:0];
            ST_DIVY_WAIT: begin
                // Apply the signs of the raw axes to the magnitudes
                if (iter_done) begin
                    if (lane_reg) begin
                        res_rx_reg <= cur_x[15] ? (~{1'b0, qx_reg} + 16'd1) : {1'b0, qx_reg};
                        res_ry_reg <= cur_y[15] ? (~{1'b0, iter_result[14:0]} + 16'd1)
                                                : {1'b0, iter_result[14:0]};
                    end else begin
                        res_lx_reg <= cur_x[15] ? (~{1'b0, qx_reg} + 16'd1) : {1'b0, qx_reg};
                        res_ly_reg <= cur_y[15] ? (~{1'b0, iter_result[14:0]} + 16'd1)
                                                : {1'b0, iter_result[14:0]};
                    end
                end
            end
            ST_TRIG_CHK: begin
                if (trig_dead) begin
                    if (lane_reg) res_rt_reg <= 15'd0;
                    else res_lt_reg <= 15'd0;
                end
            end
            ST_TRIG_WAIT: begin
                if (iter_done) begin
                    if (lane_reg) res_rt_reg <= iter_result[14:0];
                    else res_lt_reg <= iter_result[14:0];
                end
            end
            default: ;
        endcase
        // Hand the finished poll to the output register
        if (out_load) begin
            out_lx_reg       <= res_lx_reg;
            out_ly_reg       <= res_ly_reg;
            out_rx_reg       <= res_rx_reg;
            out_ry_reg       <= res_ry_reg;
            out_lt_reg       <= res_lt_reg;
            out_rt_reg       <= res_rt_reg;
            out_held_reg     <= held_reg;
            out_pressed_reg  <= pressed_reg;
            out_released_reg <= released_reg;
        end
    end

    assign cfg_ready           = aresetn;
    assign m_valid             = m_valid_reg;
    assign m_left_x_out        = out_lx_reg;
    assign m_left_y_out        = out_ly_reg;
    assign m_right_x_out       = out_rx_reg;
    assign m_right_y_out       = out_ry_reg;
    assign m_left_trigger_out  = out_lt_reg;
    assign m_right_trigger_out = out_rt_reg;
    assign m_held_mask         = out_held_reg;
    assign m_pressed_mask      = out_pressed_reg;
    assign m_released_mask     = out_released_reg;

    // Conditions for the checks
    assign edges_overlap  = |(m_pressed_mask & m_released_mask);
    assign pressed_unheld = |(m_pressed_mask & ~m_held_mask);
    assign iter_in_wait   = state_reg inside {ST_ROOT_WAIT, ST_DIVX_WAIT,
                                              ST_DIVY_WAIT, ST_TRIG_WAIT};

    // Checks
    `GPDZ_ASSERT_NEXT(a_accept_blocks_input, aclk, aresetn, s_valid && s_ready, !s_ready)
    `GPDZ_ASSERT_NOW(a_edges_disjoint, aclk, aresetn, m_valid, !edges_overlap)
    `GPDZ_ASSERT_NOW(a_pressed_is_held, aclk, aresetn, m_valid, !pressed_unheld)
    `GPDZ_ASSERT_NOW(a_done_in_wait, aclk, aresetn, iter_done, iter_in_wait)

endmodule

// File: rtl/core/gpdz_iter.sv
// Shared iterative unit: 32-bit integer square root (two bits a step) or a
// 45-by-31-bit division with a 15-bit quotient (one bit a step). Uses gpdz_pkg.
module gpdz_iter (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  gpdz_pkg::gpdz_iter_ctrl_t ctrl,
    input  logic [44:0]               num,
    input  logic [30:0]               den,
    output logic [15:0]               result,
    output logic                      done
);
    import gpdz_pkg::*;

    localparam logic [3:0] SQRT_LAST = 4'd15;
    localparam logic [3:0] DIV_LAST  = 4'd14;

    logic [44:0] rem_reg;
    logic [44:0] rem_next;
    logic [44:0] dsh_reg;
    logic [31:0] src_reg;
    logic [15:0] acc_reg;
    logic [15:0] acc_next;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    gpdz_op_t    op_reg;

    logic [44:0] opa;
    logic [44:0] opb;
    logic [45:0] diff;
    logic        ge;

    // Select operands of the one shared subtractor
    always_comb begin
        case (op_reg)
            OP_SQRT: begin
                opa = {25'd0, rem_reg[17:0], src_reg[31:30]};
                opb = {27'd0, acc_reg, 2'b01};
            end
            OP_DIV: begin
                opa = rem_reg;
                opb = dsh_reg;
            end
            default: begin
                opa = rem_reg;
                opb = dsh_reg;
            end
        endcase
    end

    // Trial subtract; keep the difference when it does not borrow
    assign diff     = {1'b0, opa} - {1'b0, opb};
    assign ge       = ~diff[45];
    assign rem_next = ge ? diff[44:0] : opa;
    assign acc_next = {acc_reg[14:0], ge};

    // Load on start, then advance one step a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_SQRT;
        end else begin
            // Flag the cycle after the last step
            done_reg <= !ctrl.start && busy_reg && (cnt_reg == 4'd0);
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                op_reg   <= ctrl.op;
                acc_reg  <= 16'd0;
                rem_reg  <= (ctrl.op == OP_SQRT) ? 45'd0 : num;
                src_reg  <= num[31:0];
                dsh_reg  <= {den, 14'd0};
                cnt_reg  <= (ctrl.op == OP_SQRT) ? SQRT_LAST : DIV_LAST;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                acc_reg <= acc_next;
                src_reg <= {src_reg[29:0], 2'b00};
                dsh_reg <= {1'b0, dsh_reg[44:1]};
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd0) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign result = acc_reg;
    assign done   = done_reg;

endmodule
